[rtl/rcrb_pkg.sv]
// Shared types and codes for the rendezvous channel.
package rcrb_pkg;

  localparam int CMD_W    = 2;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 3;
  localparam int BUFLEN_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND   = 2'd0,
    CMD_RECV   = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NOT_PENDING = 3'd0,
    ST_DONE        = 3'd1,
    ST_QUEUED      = 3'd2,
    ST_FULL        = 3'd3,
    ST_CANCELLED   = 3'd4,
    ST_NOT_FOUND   = 3'd5
  } status_t;

endpackage

[rtl/rcrb_req_if.sv]
// Request and result channel interfaces.
interface rcrb_req_if #(parameter int DATA_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [7:0]           tid;
  logic [DATA_BITS-1:0] data_word;
  logic                 caller_pending;
  modport source (output valid, command, tid, data_word, caller_pending, input ready);
  modport sink   (input valid, command, tid, data_word, caller_pending, output ready);
endinterface

interface rcrb_rsp_if #(parameter int DATA_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [DATA_BITS-1:0] caller_data;
  logic                 partner_valid;
  logic [7:0]           partner_thread;
  logic [DATA_BITS-1:0] partner_data;
  modport source (output valid, status, caller_data, partner_valid, partner_thread,
                  partner_data, input ready);
  modport sink   (input valid, status, caller_data, partner_valid, partner_thread,
                  partner_data, output ready);
endinterface

[rtl/rcrb_ring_mem.sv]
// Ring buffer word memory with registered read.
module rcrb_ring_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/rcrb_wait_mem.sv]
// Wait queue entry memory (thread id, plus the word in send queue entries) with registered read.
module rcrb_wait_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 40,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/rendezvous_channel_with_ring_buffer.sv]
// Request channel with a ring buffer and two wait queues held in memories with a
// registered read. A result is presented after its request has passed through the
// read, decide and output states. Releasing a waiter compacts the queue, moving
// each entry behind the released one down one slot, and a receive that refills
// the ring from a waiting sender first passes through a ring refill state. A
// cancel compares one entry a cycle, receivers first, and searches the send queue
// only when no waiting receiver matches. The result sits in an output register and
// the next request is taken the cycle after the result has been delivered. Writing
// the buffer length register empties the ring.
module rendezvous_channel_with_ring_buffer #(
  parameter int BUF_DEPTH  = 16,
  parameter int WAIT_DEPTH = 8,
  parameter int DATA_BITS  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [4:0]              cfg_wdata,
  rcrb_req_if.sink                in_req,
  rcrb_rsp_if.source              out_rsp
);
  import rcrb_pkg::*;

  localparam int BA = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int WA = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int BC = $clog2(BUF_DEPTH + 1);
  localparam int WC = $clog2(WAIT_DEPTH + 1);
  localparam int EW = TID_W + DATA_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_RPUT  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [BUFLEN_W-1:0] blen_r;
  logic [BC-1:0] len;
  assign len = (32'(blen_r) > BUF_DEPTH) ? BC'(BUF_DEPTH) : BC'(blen_r);

  logic [BA-1:0] head_r, head_nxt;
  logic [BC-1:0] rcnt_r, rcnt_nxt;
  logic [WC-1:0] scnt_r, scnt_nxt, qcnt_r, qcnt_nxt;

  // request latch
  logic [CMD_W-1:0] cmd_r;
  logic [TID_W-1:0] tid_r;
  logic [DATA_BITS-1:0] word_r;
  logic pend_r;

  // scan/shift bookkeeping
  logic [WC-1:0] idx_r, idx_nxt;
  logic q_is_send_r, q_is_send_nxt;
  logic [DATA_BITS-1:0] sw_r, sw_nxt;

  // result register
  logic out_v_r, out_v_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [DATA_BITS-1:0] cd_r, cd_nxt, pd_r, pd_nxt;
  logic pv_r, pv_nxt;
  logic [TID_W-1:0] pt_r, pt_nxt;

  // memories
  logic          rg_we;
  logic [BA-1:0] rg_wa, rg_ra;
  logic [DATA_BITS-1:0] rg_wd, rg_rd;
  logic          sq_we, rq_we;
  logic [WA-1:0] sq_wa, sq_ra, rq_wa, rq_ra;
  logic [EW-1:0] sq_wd, sq_rd;
  logic [TID_W-1:0] rq_wd, rq_rd;

  rcrb_ring_mem #(.DEPTH(BUF_DEPTH), .WIDTH(DATA_BITS), .AW(BA)) u_ring (
    .clk, .we(rg_we), .waddr(rg_wa), .wdata(rg_wd), .raddr(rg_ra), .rdata(rg_rd));
  rcrb_wait_mem #(.DEPTH(WAIT_DEPTH), .WIDTH(EW), .AW(WA)) u_sendq (
    .clk, .we(sq_we), .waddr(sq_wa), .wdata(sq_wd), .raddr(sq_ra), .rdata(sq_rd));
  rcrb_wait_mem #(.DEPTH(WAIT_DEPTH), .WIDTH(TID_W), .AW(WA)) u_recvq (
    .clk, .we(rq_we), .waddr(rq_wa), .wdata(rq_wd), .raddr(rq_ra), .rdata(rq_rd));

  // tail slot of the ring: (head + count) wrapped by len
  logic [BC:0] tail_sum;
  logic [BA-1:0] tail;
  always_comb begin
    tail_sum = (BC+1)'(head_r) + (BC+1)'(rcnt_r);
    if (tail_sum >= (BC+1)'(len)) tail_sum = tail_sum - (BC+1)'(len);
    tail = (tail_sum >= (BC+1)'(BUF_DEPTH)) ? '0 : tail_sum[BA-1:0];
  end

  logic [BC:0] head_inc;
  assign head_inc = (BC+1)'(head_r) + 1'b1;

  logic [WC-1:0] idx_p1, idx_p2;
  assign idx_p1 = idx_r + 1'b1;
  assign idx_p2 = idx_r + WC'(2);

  assign in_req.ready = (state_r == S_IDLE) && !out_v_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r; rcnt_nxt = rcnt_r; scnt_nxt = scnt_r; qcnt_nxt = qcnt_r;
    idx_nxt = idx_r; q_is_send_nxt = q_is_send_r; sw_nxt = sw_r;
    out_v_nxt = out_v_r; st_nxt = st_r; cd_nxt = cd_r; pv_nxt = pv_r;
    pt_nxt = pt_r; pd_nxt = pd_r;
    rg_we = 1'b0; rg_wa = tail; rg_wd = word_r; rg_ra = head_r;
    sq_we = 1'b0; sq_wa = scnt_r[WA-1:0]; sq_wd = {tid_r, word_r}; sq_ra = '0;
    rq_we = 1'b0; rq_wa = qcnt_r[WA-1:0]; rq_wd = tid_r; rq_ra = '0;
    if (out_v_r && out_rsp.ready) out_v_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid && in_req.ready) state_nxt = S_READ;
      end
      S_READ: begin
        // address heads; data arrives next cycle
        idx_nxt = '0;
        st_nxt = ST_NOT_PENDING; cd_nxt = '0; pv_nxt = 1'b0; pt_nxt = '0; pd_nxt = '0;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_OUT;
        if (cmd_r == CMD_SEND && pend_r) begin
          if (qcnt_r != '0) begin
            pt_nxt = rq_rd; pv_nxt = 1'b1; pd_nxt = word_r; st_nxt = ST_DONE;
            q_is_send_nxt = 1'b0; rq_ra = idx_p1[WA-1:0];
            state_nxt = S_SHIFT;
          end else if (len != '0 && rcnt_r < len) begin
            rg_we = 1'b1; rcnt_nxt = rcnt_r + 1'b1; st_nxt = ST_DONE;
          end else if (32'(scnt_r) < WAIT_DEPTH) begin
            sq_we = 1'b1; scnt_nxt = scnt_r + 1'b1; st_nxt = ST_QUEUED;
          end else st_nxt = ST_FULL;
        end else if (cmd_r == CMD_RECV && pend_r) begin
          if (scnt_r != '0) begin
            pt_nxt = sq_rd[EW-1:DATA_BITS]; pv_nxt = 1'b1; st_nxt = ST_DONE;
            q_is_send_nxt = 1'b1; sq_ra = idx_p1[WA-1:0];
            if (len != '0 && rcnt_r != '0) begin
              cd_nxt = rg_rd; sw_nxt = sq_rd[DATA_BITS-1:0];
              head_nxt = (head_inc >= (BC+1)'(len)) ? '0 : head_inc[BA-1:0];
              rcnt_nxt = rcnt_r - 1'b1;
              state_nxt = S_RPUT;
            end else begin
              cd_nxt = sq_rd[DATA_BITS-1:0];
              state_nxt = S_SHIFT;
            end
          end else if (len != '0 && rcnt_r != '0) begin
            cd_nxt = rg_rd; st_nxt = ST_DONE;
            head_nxt = (head_inc >= (BC+1)'(len)) ? '0 : head_inc[BA-1:0];
            rcnt_nxt = rcnt_r - 1'b1;
          end else if (32'(qcnt_r) < WAIT_DEPTH) begin
            rq_we = 1'b1; qcnt_nxt = qcnt_r + 1'b1; st_nxt = ST_QUEUED;
          end else st_nxt = ST_FULL;
        end else if (cmd_r == CMD_CANCEL) begin
          st_nxt = ST_NOT_FOUND;
          q_is_send_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_RPUT: begin
        // refill the ring tail with the released sender's word; keep entry 1 in view
        rg_we = 1'b1; rg_wd = sw_r; rcnt_nxt = rcnt_r + 1'b1;
        sq_ra = idx_p1[WA-1:0];
        state_nxt = S_SHIFT;
      end
      S_SCAN: begin
        // read data holds entry idx_r of the queue being searched
        if (!q_is_send_r) begin
          rq_ra = idx_p1[WA-1:0];
          if (idx_r >= qcnt_r) begin
            // send queue head is still in view
            q_is_send_nxt = 1'b1; idx_nxt = '0;
          end else if (rq_rd == tid_r) begin
            st_nxt = ST_CANCELLED; state_nxt = S_SHIFT;
          end else idx_nxt = idx_p1;
        end else begin
          sq_ra = idx_p1[WA-1:0];
          if (idx_r >= scnt_r) begin
            state_nxt = S_OUT;
          end else if (sq_rd[EW-1:DATA_BITS] == tid_r) begin
            st_nxt = ST_CANCELLED; state_nxt = S_SHIFT;
          end else idx_nxt = idx_p1;
        end
      end
      S_SHIFT: begin
        // read data holds entry idx_r+1; move it down and read one ahead
        if (q_is_send_r) begin
          sq_ra = idx_p2[WA-1:0];
          if (idx_p1 >= scnt_r) begin
            scnt_nxt = scnt_r - 1'b1; state_nxt = S_OUT;
          end else begin
            sq_we = 1'b1; sq_wa = idx_r[WA-1:0]; sq_wd = sq_rd; idx_nxt = idx_p1;
          end
        end else begin
          rq_ra = idx_p2[WA-1:0];
          if (idx_p1 >= qcnt_r) begin
            qcnt_nxt = qcnt_r - 1'b1; state_nxt = S_OUT;
          end else begin
            rq_we = 1'b1; rq_wa = idx_r[WA-1:0]; rq_wd = rq_rd; idx_nxt = idx_p1;
          end
        end
      end
      S_OUT: begin
        if (!out_v_r) begin
          out_v_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; blen_r <= '0; head_r <= '0; rcnt_r <= '0;
      scnt_r <= '0; qcnt_r <= '0; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; scnt_r <= scnt_nxt; qcnt_r <= qcnt_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        blen_r <= cfg_wdata; head_r <= '0; rcnt_r <= '0;
      end else begin
        head_r <= head_nxt; rcnt_r <= rcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      cmd_r <= in_req.command; tid_r <= in_req.tid;
      word_r <= in_req.data_word; pend_r <= in_req.caller_pending;
    end
    idx_r <= idx_nxt; q_is_send_r <= q_is_send_nxt; sw_r <= sw_nxt;
    st_r <= st_nxt; cd_r <= cd_nxt; pv_r <= pv_nxt; pt_r <= pt_nxt; pd_r <= pd_nxt;
  end

  assign out_rsp.valid          = out_v_r;
  assign out_rsp.status         = st_r;
  assign out_rsp.caller_data    = cd_r;
  assign out_rsp.partner_valid  = pv_r;
  assign out_rsp.partner_thread = pt_r;
  assign out_rsp.partner_data   = pd_r;

`ifndef SYNTHESIS
  a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= BC'(BUF_DEPTH)) else $error("ring count overflow");
  a_scnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scnt_r) <= WAIT_DEPTH) else $error("send queue overflow");
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready) else $error("request overlap");
`endif
endmodule
